// ===== sv/rme_pkg.sv =====
// rme_pkg: shared constants, types and helper functions for the
// rotation matrix to euler angles block (cordic angle table, word layouts)
package rme_pkg;

  localparam int unsigned AngW    = 34;  // q2.30 angle plus guard bits
  localparam int unsigned TabLen  = 24;
  localparam int unsigned ElemW   = 16;
  localparam int unsigned FracBits = 14;  // q1.14 matrix elements
  localparam int unsigned InDataW = 112;
  localparam int unsigned OutDataW = 48;
  localparam logic signed [AngW-1:0] HalfPiQ30 = 34'sd1686629713;
  localparam logic signed [15:0] PiQ13     = 16'sd25736;
  localparam logic signed [15:0] HalfPiQ13 = 16'sd12868;

  typedef logic signed [AngW-1:0] ang_t;

  function automatic ang_t atan_entry(input int unsigned i);
    ang_t r;
    r = '0;
    unique case (i)
      0: r = 34'sh3243F6A8;  1: r = 34'sh1DAC6705;  2: r = 34'sh0FADBAFC;
      3: r = 34'sh07F56EA6;  4: r = 34'sh03FEAB76;  5: r = 34'sh01FFD55B;
      6: r = 34'sh00FFFAAA;  7: r = 34'sh007FFF55;  8: r = 34'sh003FFFEA;
      9: r = 34'sh001FFFFD;  10: r = 34'sh000FFFFF; 11: r = 34'sh0007FFFF;
      12: r = 34'sh0003FFFF; 13: r = 34'sh0001FFFF; 14: r = 34'sh0000FFFF;
      15: r = 34'sh00007FFF; 16: r = 34'sh00003FFF; 17: r = 34'sh00001FFF;
      18: r = 34'sh00000FFF; 19: r = 34'sh000007FF; 20: r = 34'sh000003FF;
      21: r = 34'sh000001FF; 22: r = 34'sh000000FF; 23: r = 34'sh0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // q2.30 to q2.13, round half up, saturate to +/-lim
  function automatic logic signed [15:0] to_q13(input ang_t z,
                                                input logic signed [15:0] lim);
    logic signed [AngW:0] t;
    logic signed [17:0]   r;
    t = {z[AngW-1], z} + (AngW+1)'(65536);
    r = 18'(t >>> 17);
    if (r > 18'(lim)) r = 18'(lim);
    if (r < -18'(lim)) r = -18'(lim);
    return r[15:0];
  endfunction

  // per-item control that rides along the chain
  typedef struct packed {
    logic lock_pos;
    logic lock_neg;
    logic order;
    logic zero_a;  // both arguments of lane 0 are zero
    logic zero_b;  // both arguments of lane 1 are zero
  } ctl_t;

endpackage

// ===== sv/rme_cell.sv =====
// rme_cell: one cordic vectoring iteration for three arctangent lanes plus
// one step of the restoring square root; depends on rme_pkg
module rme_cell #(
  parameter int unsigned StageA = 0,
  parameter int unsigned OnA    = 1,
  parameter int unsigned StageB = 0,
  parameter int unsigned OnB    = 0,
  parameter int unsigned XW     = 36
) (
  input  logic                      clk_i,
  input  logic                      en_i,
  input  logic signed [XW-1:0]      x_i [3],
  input  logic signed [XW-1:0]      y_i [3],
  input  rme_pkg::ang_t             z_i [3],
  input  logic [31:0]               sq_rem_i,
  input  logic [31:0]               sq_res_i,
  input  logic [31:0]               sq_bit_i,
  input  logic [15:0]               s_i,
  output logic signed [XW-1:0]      x_o [3],
  output logic signed [XW-1:0]      y_o [3],
  output rme_pkg::ang_t             z_o [3],
  output logic [31:0]               sq_rem_o,
  output logic [31:0]               sq_res_o,
  output logic [31:0]               sq_bit_o,
  output logic [15:0]               s_o
);

  logic signed [XW-1:0] x_d [3];
  logic signed [XW-1:0] y_d [3];
  rme_pkg::ang_t        z_d [3];
  logic [31:0]          rem_d, res_d;

  // lanes 0/1 use stage a, lane 2 (pitch) uses stage b
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      if ((l < 2) ? (OnA != 0) : (OnB != 0)) begin
        if (!y_i[l][XW-1]) begin
          x_d[l] = x_i[l] + (y_i[l] >>> ((l < 2) ? StageA : StageB));
          y_d[l] = y_i[l] - (x_i[l] >>> ((l < 2) ? StageA : StageB));
          z_d[l] = z_i[l] + rme_pkg::atan_entry((l < 2) ? StageA : StageB);
        end else begin
          x_d[l] = x_i[l] - (y_i[l] >>> ((l < 2) ? StageA : StageB));
          y_d[l] = y_i[l] + (x_i[l] >>> ((l < 2) ? StageA : StageB));
          z_d[l] = z_i[l] - rme_pkg::atan_entry((l < 2) ? StageA : StageB);
        end
      end else begin
        x_d[l] = x_i[l];
        y_d[l] = y_i[l];
        z_d[l] = z_i[l];
      end
    end
    if (sq_rem_i >= sq_res_i + sq_bit_i) begin
      rem_d = sq_rem_i - (sq_res_i + sq_bit_i);
      res_d = (sq_res_i >> 1) + sq_bit_i;
    end else begin
      rem_d = sq_rem_i;
      res_d = sq_res_i >> 1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o      <= x_d;
      y_o      <= y_d;
      z_o      <= z_d;
      sq_rem_o <= rem_d;
      sq_res_o <= res_d;
      sq_bit_o <= sq_bit_i >> 2;
      s_o      <= s_i;
    end
  end

endmodule

// ===== sv/rotation_matrix_to_euler_angles.sv =====
// rotation_matrix_to_euler_angles: top level, input pre-rotation, chain of
// cordic/sqrt cells, pitch cordic chain, rounding and output register; uses rme_pkg
//
//   channel | dir | handshake        | payload
//   s_axis  | in  | tvalid / tready  | tdata: elem_11..elem_33, 16 bits each
//   m_axis  | out | tvalid / tready  | tdata: yaw, pitch, roll; tuser: is_unique
//   cfg     | in  | cfg_we_i         | axis_order in bit 0
//
// one word per cycle while m_axis is not stalled; the path is the square root
// chain (16 cells), followed by the pitch cordic chain and the output register.
// the whole pipeline advances when the output register is free or taken;
// a stall on m_axis holds every stage. reset clears only valid bits and mode.
module rotation_matrix_to_euler_angles #(
  parameter int unsigned CORDIC_STAGES   = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [0:0]   cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // elem_11, elem_12, elem_13, elem_21, elem_22, elem_23, elem_33
  input  logic [111:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // yaw_angle[15:0], pitch_angle[30:16], roll_angle[46:31], zero[47]
  output logic [47:0]  m_axis_tdata,
  // is_unique[0]
  output logic [0:0]   m_axis_tuser
);

  localparam int unsigned XW    = 36;
  localparam int unsigned SqN   = 16;
  localparam int unsigned Chain = SqN + CORDIC_STAGES;
  localparam int unsigned Shift = 30 - rme_pkg::FracBits;
  localparam logic signed [17:0] One = 18'sd1 <<< rme_pkg::FracBits;
  localparam logic [31:0] OneSq = 32'd1 << (2 * rme_pkg::FracBits);

  typedef logic signed [XW-1:0] xv_t;

  logic order_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) order_q <= 1'b0;
    else if (cfg_we_i) order_q <= cfg_wdata_i[0];
  end

  logic adv;
  logic out_v_q;
  assign adv = !out_v_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = out_v_q;

  // saturate inputs
  logic signed [17:0] m [7];
  always_comb begin
    for (int k = 0; k < 7; k++) begin
      m[k] = 18'(signed'(s_axis_tdata[k*16 +: 16]));
      if (m[k] > One) m[k] = One;
      if (m[k] < -One) m[k] = -One;
    end
  end

  // pre-rotate into the right half plane
  function automatic void prerot(input logic signed [17:0] y, x,
                                 output xv_t xo, yo, output rme_pkg::ang_t zo);
    xv_t xs, ys;
    xs = XW'(x) <<< Shift;
    ys = XW'(y) <<< Shift;
    xo = xs; yo = ys; zo = '0;
    if (x == 0 && y == 0) begin
      xo = '0; yo = '0;
    end else if (x < 0) begin
      if (y >= 0) begin xo = ys; yo = -xs; zo = rme_pkg::HalfPiQ30; end
      else begin xo = -ys; yo = xs; zo = -rme_pkg::HalfPiQ30; end
    end
  endfunction

  logic signed [17:0] s_c, ly, lx, ay, ax, by, bx;
  rme_pkg::ctl_t ctl_c;
  always_comb begin
    if (!order_q) begin
      s_c = -m[5]; ly = -m[1]; lx = m[0];
      ay = m[2];   ax = m[6];  by = m[3]; bx = m[4];
    end else begin
      s_c = m[2];  ly = m[3];  lx = m[4];
      ay = -m[5];  ax = m[6];  by = -m[1]; bx = m[0];
    end
    ctl_c.lock_pos = (s_c >= One);
    ctl_c.lock_neg = (s_c <= -One);
    ctl_c.order    = order_q;
    ctl_c.zero_a   = (ctl_c.lock_pos || ctl_c.lock_neg) ? (ly == 0 && lx == 0)
                                                        : (ay == 0 && ax == 0);
    ctl_c.zero_b   = (by == 0 && bx == 0);
  end

  xv_t x0 [3], y0 [3];
  rme_pkg::ang_t z0 [3];
  logic [31:0] rem0;
  logic signed [35:0] s_w, s_sq;
  always_comb begin
    prerot(ctl_c.lock_pos || ctl_c.lock_neg ? ly : ay,
           ctl_c.lock_pos || ctl_c.lock_neg ? lx : ax, x0[0], y0[0], z0[0]);
    prerot(by, bx, x0[1], y0[1], z0[1]);
    x0[2] = '0; y0[2] = '0; z0[2] = '0;
    s_w = 36'(s_c);
    s_sq = s_w * s_w;
    rem0 = OneSq - s_sq[31:0];
  end

  xv_t cx [Chain+1][3];
  xv_t cy [Chain+1][3];
  rme_pkg::ang_t cz [Chain+1][3];
  logic [31:0] crem [Chain+1], cres [Chain+1], cbit [Chain+1];
  logic [15:0] cs [Chain+1];
  logic [Chain-1:0] vld_q;
  rme_pkg::ctl_t ctl_q [Chain];

  assign cx[0] = x0; assign cy[0] = y0; assign cz[0] = z0;
  assign crem[0] = rem0; assign cres[0] = '0; assign cbit[0] = 32'h4000_0000;
  assign cs[0] = s_c[15:0];

  // first SqN cells: sqrt steps; lanes 0/1 iterate in the first CORDIC_STAGES
  // cells, then CORDIC_STAGES cells run the pitch lane (lane 2) from s and sqrt
  for (genvar g = 0; g < Chain; g++) begin : g_cell
    xv_t xi [3], yi [3];
    rme_pkg::ang_t zi [3];
    if (g == SqN) begin : g_seed
      always_comb begin
        xi = cx[g]; yi = cy[g]; zi = cz[g];
        prerot(18'(signed'(cs[g])), 18'(cres[g]), xi[2], yi[2], zi[2]);
      end
    end else begin : g_pass
      assign xi = cx[g]; assign yi = cy[g]; assign zi = cz[g];
    end
    rme_cell #(
      .StageA (g < CORDIC_STAGES ? g : 0),
      .OnA    (g < CORDIC_STAGES ? 1 : 0),
      .StageB (g < SqN ? 0 : g - SqN),
      .OnB    (g < SqN ? 0 : 1),
      .XW     (XW)
    ) u_cell (
      .clk_i, .en_i(adv),
      .x_i(xi), .y_i(yi), .z_i(zi),
      .sq_rem_i(crem[g]), .sq_res_i(cres[g]), .sq_bit_i(cbit[g]), .s_i(cs[g]),
      .x_o(cx[g+1]), .y_o(cy[g+1]), .z_o(cz[g+1]),
      .sq_rem_o(crem[g+1]), .sq_res_o(cres[g+1]), .sq_bit_o(cbit[g+1]),
      .s_o(cs[g+1])
    );
  end

  // valid bit and control of each cell's word
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else if (adv) vld_q <= {vld_q[Chain-2:0], s_axis_tvalid};
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctl_q[0] <= ctl_c;
      for (int k = 1; k < Chain; k++) ctl_q[k] <= ctl_q[k-1];
    end
  end

  // lanes 0/1 finished early: hold their angles in delay cells
  // (cells past CORDIC_STAGES pass them unchanged, so cz[Chain] is final)
  logic signed [15:0] yaw_r, roll_r, pitch_r, a0, a1, ap;
  rme_pkg::ctl_t cf;
  always_comb begin
    cf = ctl_q[Chain-1];
    // atan2 of two zero arguments is zero
    a0 = cf.zero_a ? '0 : rme_pkg::to_q13(cz[Chain][0], rme_pkg::PiQ13);
    a1 = cf.zero_b ? '0 : rme_pkg::to_q13(cz[Chain][1], rme_pkg::PiQ13);
    ap = rme_pkg::to_q13(cz[Chain][2], rme_pkg::HalfPiQ13);
    if (cf.lock_pos) begin
      yaw_r = a0; pitch_r = rme_pkg::HalfPiQ13; roll_r = '0;
    end else if (cf.lock_neg) begin
      yaw_r = -a0; pitch_r = -rme_pkg::HalfPiQ13; roll_r = '0;
    end else begin
      yaw_r = a0; pitch_r = ap;
      roll_r = cf.order ? a1 : -a1;
    end
  end

  logic [47:0] out_q;
  logic        uniq_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (adv) out_v_q <= vld_q[Chain-1];
  end
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q  <= {1'b0, roll_r, pitch_r[14:0], yaw_r};
      uniq_q <= !(cf.lock_pos || cf.lock_neg);
    end
  end
  assign m_axis_tdata = out_q;
  assign m_axis_tuser = uniq_q;

`ifndef NO_ASSERTIONS
  a_lock_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Chain-1] |-> !(cf.lock_pos && cf.lock_neg)) else $error("both lock sides");
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output changed under stall");
  a_lock_roll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser[0]) |-> m_axis_tdata[46:31] == 16'd0)
    else $error("roll nonzero at lock");
`endif

endmodule

// ===== tb/rotation_matrix_to_euler_angles_tb.sv =====
// testbench for rotation_matrix_to_euler_angles: drives matrices over s_axis,
// predicts yaw/pitch/roll with a cordic angle model and checks m_axis words
// depends on rme_pkg and the rotation_matrix_to_euler_angles rtl
`timescale 1ns / 100ps

module rotation_matrix_to_euler_angles_tb;

  localparam int unsigned Stages   = 16;
  localparam int unsigned FracBits = 14;
  localparam longint      One      = 64'sd1 << FracBits;
  localparam int unsigned Latency  = 16 + Stages + 1;

  typedef struct packed {
    logic        unique_sol;
    logic [15:0] roll;
    logic [14:0] pitch;
    logic [15:0] yaw;
  } angles_t;

  typedef logic [111:0] matrix_t;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          cfg_we_i = 1'b0;
  logic [0:0]    cfg_wdata_i = '0;
  logic          s_axis_tvalid = 1'b0;
  logic          s_axis_tready;
  logic [111:0]  s_axis_tdata = '0;
  logic          m_axis_tvalid;
  logic          m_axis_tready = 1'b0;
  logic [47:0]   m_axis_tdata;
  logic [0:0]    m_axis_tuser;

  matrix_t matrix_q[$];
  angles_t angles_q[$];
  bit      order_mode = 1'b0;
  int      src_idle_pct = 0;
  int      snk_stall_pct = 0;
  int      fail_cnt = 0;

  rotation_matrix_to_euler_angles u_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #6 clk_i = ~clk_i;

  function automatic longint sat_one(input logic [15:0] v);
    longint r;
    r = longint'($signed(v));
    if (r > One) r = One;
    if (r < -One) r = -One;
    return r;
  endfunction

  function automatic longint shr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint atan_q30(input longint y_in, input longint x_in);
    longint x, y, z, t, xs, ys;
    x = x_in <<< (30 - FracBits);
    y = y_in <<< (30 - FracBits);
    z = 0;
    if (x_in == 0 && y_in == 0) return 0;
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; z = 1686629713;
      end else begin
        t = x; x = -y; y = t; z = -1686629713;
      end
    end
    for (int i = 0; i < Stages; i++) begin
      xs = shr(x, i);
      ys = shr(y, i);
      if (y >= 0) begin
        x += ys; y -= xs; z += longint'(rme_pkg::atan_entry(i));
      end else begin
        x -= ys; y += xs; z -= longint'(rme_pkg::atan_entry(i));
      end
    end
    return z;
  endfunction

  function automatic longint round_q13(input longint z, input longint lim);
    longint r;
    r = (z + 64'sd65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint root_floor(input longint n);
    longint r;
    r = 0;
    while ((r + 1) * (r + 1) <= n) r++;
    return r;
  endfunction

  function automatic angles_t solve_angles(input matrix_t m, input bit ord);
    longint e11, e12, e13, e21, e22, e23, e33, s, ly, lx, yw, pt, rl;
    angles_t a;
    e11 = sat_one(m[15:0]);   e12 = sat_one(m[31:16]); e13 = sat_one(m[47:32]);
    e21 = sat_one(m[63:48]);  e22 = sat_one(m[79:64]); e23 = sat_one(m[95:80]);
    e33 = sat_one(m[111:96]);
    if (!ord) begin
      s = -e23; ly = -e12; lx = e11;
    end else begin
      s = e13; ly = e21; lx = e22;
    end
    a.unique_sol = 1'b0;
    rl = 0;
    if (s >= One) begin
      pt = 12868;
      yw = round_q13(atan_q30(ly, lx), 25736);
    end else if (s <= -One) begin
      pt = -12868;
      yw = -round_q13(atan_q30(ly, lx), 25736);
    end else begin
      pt = round_q13(atan_q30(s, root_floor(One * One - s * s)), 12868);
      if (!ord) begin
        yw = round_q13(atan_q30(e13, e33), 25736);
        rl = -round_q13(atan_q30(e21, e22), 25736);
      end else begin
        yw = round_q13(atan_q30(-e23, e33), 25736);
        rl = round_q13(atan_q30(-e12, e11), 25736);
      end
      a.unique_sol = 1'b1;
    end
    a.yaw = yw[15:0];
    a.pitch = pt[14:0];
    a.roll = rl[15:0];
    return a;
  endfunction

  // driver: predicts at acceptance so the mode in force is the one used
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      angles_q.push_back(solve_angles(s_axis_tdata, order_mode));
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (matrix_q.size() > 0 && rst_ni &&
          $urandom_range(99, 0) >= src_idle_pct) begin
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= matrix_q.pop_front();
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
    m_axis_tready <= $urandom_range(99, 0) >= snk_stall_pct;
  end

  // monitor
  always @(posedge clk_i) begin
    angles_t got, want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = {m_axis_tuser[0], m_axis_tdata[46:0]};
      if (angles_q.size() == 0) begin
        $display("%0t: unexpected word %h", $time, got);
        fail_cnt++;
      end else begin
        want = angles_q.pop_front();
        if (got.yaw !== want.yaw)
          $display("%0t: yaw exp %h got %h", $time, want.yaw, got.yaw);
        if (got.pitch !== want.pitch)
          $display("%0t: pitch exp %h got %h", $time, want.pitch, got.pitch);
        if (got.roll !== want.roll)
          $display("%0t: roll exp %h got %h", $time, want.roll, got.roll);
        if (got.unique_sol !== want.unique_sol)
          $display("%0t: unique exp %b got %b", $time, want.unique_sol,
                   got.unique_sol);
        if (got !== want) fail_cnt++;
      end
    end
  end

  function automatic logic [15:0] rand_elem();
    int k;
    k = $urandom_range(9, 0);
    if (k == 0) return 16'($urandom());
    if (k == 1) return $urandom_range(1, 0) ? 16'sd16384 : -16'sd16384;
    return 16'($signed($urandom_range(32768, 0)) - 16384);
  endfunction

  function automatic matrix_t rand_matrix();
    matrix_t m;
    for (int i = 0; i < 7; i++) m[i*16 +: 16] = rand_elem();
    // force gimbal lock on either order now and then
    if ($urandom_range(7, 0) == 0) begin
      m[95:80] = $urandom_range(1, 0) ? 16'h4000 + 16'($urandom_range(5, 0))
                                     : 16'hC000 - 16'($urandom_range(5, 0));
      m[47:32] = $urandom_range(1, 0) ? 16'h4000 : 16'hC000;
    end
    return m;
  endfunction

  function automatic matrix_t pack_all(input logic [15:0] v);
    return {7{v}};
  endfunction

  task automatic drain();
    while (matrix_q.size() > 0 || s_axis_tvalid || angles_q.size() > 0)
      @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  task automatic set_order(input bit v);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    order_mode <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input bit ord, input int n, input int idle,
                           input int stall);
    set_order(ord);
    src_idle_pct = idle;
    snk_stall_pct = stall;
    for (int i = 0; i < n; i++) matrix_q.push_back(rand_matrix());
    drain();
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    for (int ord = 0; ord < 2; ord++) begin
      set_order(ord[0]);
      matrix_q.push_back('0);                        // all zero: atan2 of zeros
      matrix_q.push_back(pack_all(16'h4000));
      matrix_q.push_back(pack_all(16'hC000));
      matrix_q.push_back(pack_all(16'h7FFF));        // saturation
      matrix_q.push_back(pack_all(16'h8000));
      matrix_q.push_back(pack_all(16'hFFFF));
      // identity
      matrix_q.push_back({16'h4000, 16'h0, 16'h4000, 16'h0, 16'h0, 16'h0, 16'h4000});
      // lock positive / negative, with zero lock pair and y zero x negative
      matrix_q.push_back({16'h0, 16'hC000, 16'h0, 16'h0, 16'h4000, 16'h0, 16'hC000});
      matrix_q.push_back({16'h0, 16'h4000, 16'h0, 16'hC000, 16'hC000, 16'h0, 16'h0});
      matrix_q.push_back({16'hC000, 16'h0, 16'h0, 16'hC000, 16'hC000, 16'h0, 16'hC000});
      matrix_q.push_back({16'h2000, 16'hDFFF, 16'h1000, 16'hF000, 16'h5555, 16'hAAAA,
                          16'h3FFF});
      drain();
    end
    run_phase(1'b0, 360, 0, 0);
    run_phase(1'b1, 360, 54, 0);
    run_phase(1'b0, 360, 0, 54);
    run_phase(1'b1, 360, 16, 16);
    if (fail_cnt == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
